[rtl/bmbs_pkg.sv]
package bmbs_pkg;

    localparam int FILE_COUNT     = 128;
    localparam int BLOCK_BYTES    = 512;
    localparam int SLOTS_PER_FILE = 8;
    localparam int POOL_BLOCKS    = 64;

    // field widths of the stream items
    localparam int MODE_W   = 2;
    localparam int FILE_ID_W = 7;
    localparam int OFFSET_W = 12;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 13;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    localparam int FILE_LIMIT = SLOTS_PER_FILE * BLOCK_BYTES;

    localparam int FILE_W = (FILE_COUNT > 1) ? $clog2(FILE_COUNT) : 1;
    localparam int SLOT_W = (SLOTS_PER_FILE > 1) ? $clog2(SLOTS_PER_FILE) : 1;
    localparam int BLK_W  = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int POS_W  = $clog2(BLOCK_BYTES);

    // data memory rows: valid bit per row stands in for zeroing
    localparam int ROW_BYTES    = (BLOCK_BYTES < 128) ? BLOCK_BYTES : 128;
    localparam int RIB_W        = $clog2(ROW_BYTES);
    localparam int ROWS_PER_BLK = BLOCK_BYTES / ROW_BYTES;
    localparam int ROWS         = POOL_BLOCKS * ROWS_PER_BLK;
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;

    // free bitmap is searched eight blocks a cycle
    localparam int GRP_BITS = 8;
    localparam int GRP_LOW_W = 3;
    localparam int GROUPS   = (POOL_BLOCKS + GRP_BITS - 1) / GRP_BITS;
    localparam int GRP_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_EVAL,
        S_SCAN,
        S_DATA,
        S_FREE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]                    size;
        logic [SLOTS_PER_FILE-1:0]            valid;
        logic [SLOTS_PER_FILE-1:0][BLK_W-1:0] blk;
    } map_row_t;

    typedef struct packed {
        logic    latch_in;
        logic    map_rd;
        logic    set_status;
        status_t status;
        logic    data_rd;
        logic    capture_byte;
        logic    write_mapped;
        logic    scan_start;
        logic    scan_next;
        logic    take_write;
        logic    free_start;
        logic    free_slot;
        logic    clear_file;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic  in_range;
        mode_t mode;
        logic  read_fail;
        logic  write_limit;
        logic  slot_mapped;
        logic  group_has_free;
        logic  scan_last;
        logic  slot_last;
        logic  out_busy;
    } dp_status_t;

endpackage

[rtl/bmbs_ctrl.sv]
module bmbs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  bmbs_pkg::dp_status_t st,
    output bmbs_pkg::dp_cmd_t    cmd
);
    import bmbs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_MAP;
            end
            S_MAP: state_next = S_EVAL;
            S_EVAL: begin
                if (!st.in_range) begin
                    state_next = S_DONE;
                end else begin
                    case (st.mode)
                        MODE_READ:  state_next = st.read_fail ? S_DONE : S_DATA;
                        MODE_WRITE: begin
                            if (st.write_limit || st.slot_mapped) state_next = S_DONE;
                            else state_next = S_SCAN;
                        end
                        MODE_FREE:  state_next = S_FREE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (st.group_has_free || st.scan_last) state_next = S_DONE;
            end
            S_DATA: state_next = S_DONE;
            S_FREE: begin
                if (st.slot_last) state_next = S_DONE;
            end
            S_DONE: begin
                if (!st.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.status = ST_OK;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            S_MAP: cmd.map_rd = 1'b1;
            S_EVAL: begin
                if (!st.in_range) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_MISSING;
                end else begin
                    case (st.mode)
                        MODE_READ: begin
                            if (st.read_fail) begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_MISSING;
                            end else begin
                                cmd.data_rd = 1'b1;
                            end
                        end
                        MODE_WRITE: begin
                            if (st.write_limit) begin
                                cmd.set_status = 1'b1;
                                cmd.status     = ST_LIMIT;
                            end else if (st.slot_mapped) begin
                                cmd.write_mapped = 1'b1;
                            end else begin
                                cmd.scan_start = 1'b1;
                            end
                        end
                        MODE_FREE: cmd.free_start = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (st.group_has_free) begin
                    cmd.take_write = 1'b1;
                end else if (st.scan_last) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FULL;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_DATA: cmd.capture_byte = 1'b1;
            S_FREE: begin
                cmd.free_slot  = 1'b1;
                cmd.clear_file = st.slot_last;
            end
            S_DONE: cmd.load_out = !st.out_busy;
            default: ;
        endcase
    end

endmodule

[rtl/bmbs_datapath.sv]
module bmbs_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [bmbs_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bmbs_pkg::M_DATA_W-1:0]    m_tdata,
    input  bmbs_pkg::dp_cmd_t                cmd,
    output bmbs_pkg::dp_status_t             st
);
    import bmbs_pkg::*;

    mode_t                 mode_reg;
    logic [FILE_ID_W-1:0]  file_reg;
    logic [OFFSET_W-1:0]   off_reg;
    logic [BYTE_W-1:0]     wd_reg;
    status_t               status_reg;
    logic [BYTE_W-1:0]     rdata_reg;

    map_row_t              map_mem [FILE_COUNT];
    map_row_t              map_raw_reg;
    logic                  map_live_reg;
    logic [FILE_COUNT-1:0] file_valid_reg;

    logic [ROW_BYTES-1:0][BYTE_W-1:0] data_mem [ROWS];
    logic [ROW_BYTES-1:0][BYTE_W-1:0] data_q_reg;
    logic                  data_live_reg;
    logic [ROWS-1:0]       row_valid_reg;

    logic [POOL_BLOCKS-1:0] used_reg;
    logic [GRP_W-1:0]      grp_reg;
    logic [SLOT_W-1:0]     slot_cnt_reg;

    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [BYTE_W-1:0]     out_rdata_reg;

    map_row_t              row;
    map_row_t              row_new;
    logic [FILE_W-1:0]     fidx;
    logic [OFFSET_W-1:0]   slot_full;
    logic [SLOT_W-1:0]     slot;
    logic [POS_W-1:0]      pos;
    logic [RIB_W-1:0]      byte_sel;
    logic [SIZE_W-1:0]     off_plus;
    logic [GROUPS*GRP_BITS-1:0] used_pad;
    logic [GRP_BITS-1:0]   grp_bits;
    logic [GRP_LOW_W-1:0]  low_idx;
    logic [BLK_W-1:0]      found_idx;
    logic [BLK_W-1:0]      wr_blk;
    logic [ROW_W-1:0]      wr_row;
    logic [ROW_W-1:0]      rd_row;
    logic [BLK_W-1:0]      free_blk;
    logic                  do_write;

    assign fidx      = FILE_W'(file_reg);
    assign row       = map_live_reg ? map_raw_reg : '0;
    assign slot_full = off_reg >> POS_W;
    assign slot      = SLOT_W'(slot_full);
    assign pos       = POS_W'(off_reg);
    assign byte_sel  = RIB_W'(pos);
    assign off_plus  = SIZE_W'(off_reg) + SIZE_W'(1);
    assign do_write  = cmd.write_mapped || cmd.take_write;
    assign free_blk  = row.blk[slot_cnt_reg];

    // blocks past the pool count as taken
    always_comb begin
        used_pad = '1;
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            used_pad[i] = used_reg[i];
        end
    end

    assign grp_bits = used_pad[grp_reg*GRP_BITS +: GRP_BITS];

    always_comb begin
        low_idx = '0;
        for (int i = GRP_BITS - 1; i >= 0; i--) begin
            if (!grp_bits[i]) low_idx = GRP_LOW_W'(i);
        end
    end

    assign found_idx = BLK_W'(int'(grp_reg) * GRP_BITS + int'(low_idx));
    assign wr_blk    = cmd.take_write ? found_idx : row.blk[slot];
    assign wr_row    = ROW_W'(int'(wr_blk) * ROWS_PER_BLK + int'(pos >> RIB_W));
    assign rd_row    = ROW_W'(int'(row.blk[slot]) * ROWS_PER_BLK + int'(pos >> RIB_W));

    always_comb begin
        row_new = row;
        if (off_plus > row.size) row_new.size = off_plus;
        if (cmd.take_write) begin
            row_new.valid[slot] = 1'b1;
            row_new.blk[slot]   = found_idx;
        end
    end

    // status toward the controller
    always_comb begin
        st.in_range       = 32'(file_reg) < FILE_COUNT;
        st.mode           = mode_reg;
        st.read_fail      = (SIZE_W'(off_reg) >= row.size) ||
                            (32'(slot_full) >= SLOTS_PER_FILE) || !row.valid[slot];
        st.write_limit    = (32'(off_reg) >= FILE_LIMIT) ||
                            (32'(slot_full) >= SLOTS_PER_FILE);
        st.slot_mapped    = row.valid[slot];
        st.group_has_free = !(&grp_bits);
        st.scan_last      = 32'(grp_reg) == GROUPS - 1;
        st.slot_last      = 32'(slot_cnt_reg) == SLOTS_PER_FILE - 1;
        st.out_busy       = out_valid_reg && !m_tready;
    end

    // item and result under construction
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            mode_reg   <= mode_t'(s_tdata[MODE_W-1:0]);
            file_reg   <= s_tdata[MODE_W +: FILE_ID_W];
            off_reg    <= s_tdata[MODE_W+FILE_ID_W +: OFFSET_W];
            wd_reg     <= s_tdata[MODE_W+FILE_ID_W+OFFSET_W +: BYTE_W];
            status_reg <= ST_OK;
            rdata_reg  <= '0;
        end
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.capture_byte) rdata_reg <= data_live_reg ? data_q_reg[byte_sel] : '0;
        if (cmd.scan_start) grp_reg <= '0;
        else if (cmd.scan_next) grp_reg <= grp_reg + GRP_W'(1);
        if (cmd.free_start) slot_cnt_reg <= '0;
        else if (cmd.free_slot) slot_cnt_reg <= slot_cnt_reg + SLOT_W'(1);
    end

    // map memory, one row per file
    always_ff @(posedge aclk) begin
        if (cmd.map_rd) begin
            map_raw_reg  <= map_mem[fidx];
            map_live_reg <= file_valid_reg[fidx];
        end
        if (do_write) map_mem[fidx] <= row_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_valid_reg <= '0;
        end else if (do_write) begin
            file_valid_reg[fidx] <= 1'b1;
        end else if (cmd.clear_file) begin
            file_valid_reg[fidx] <= 1'b0;
        end
    end

    // data memory; a row not yet valid is written whole with zeros around the byte
    always_ff @(posedge aclk) begin
        if (cmd.data_rd) begin
            data_q_reg    <= data_mem[rd_row];
            data_live_reg <= row_valid_reg[rd_row];
        end
        if (do_write) begin
            for (int i = 0; i < ROW_BYTES; i++) begin
                if (RIB_W'(i) == byte_sel) begin
                    data_mem[wr_row][i] <= wd_reg;
                end else if (!row_valid_reg[wr_row]) begin
                    data_mem[wr_row][i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            used_reg      <= '0;
        end else begin
            if (do_write) row_valid_reg[wr_row] <= 1'b1;
            if (cmd.take_write) used_reg[found_idx] <= 1'b1;
            if (cmd.free_slot && row.valid[slot_cnt_reg]) begin
                used_reg[free_blk] <= 1'b0;
                for (int r = 0; r < ROWS_PER_BLK; r++) begin
                    row_valid_reg[ROW_W'(int'(free_blk) * ROWS_PER_BLK + r)] <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_rdata_reg  <= rdata_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_rdata_reg, out_status_reg});

    a_load_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(out_valid_reg && !m_tready))
        else $error("result loaded over an untaken result");

    a_take_has_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_write |-> (!used_pad[found_idx] && !row.valid[slot]))
        else $error("block taken that is in use or slot already mapped");

    a_free_clears_file: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_file |=> !file_valid_reg[$past(fidx)])
        else $error("file map still live after free");

endmodule

[rtl/block_mapped_byte_store_unit.sv]
// byte store over a shared block pool, one block map and size per file
// input stream: one request per item (read byte, write byte, free file)
// result stream: exactly one result per request, in request order
// s_tdata is 32 bits: mode, file_id, offset, write_data from bit 0 up
// m_tdata is 16 bits: status, read_data from bit 0 up
// steps per item, acceptance to result register; read: map read, evaluate, data read
//   write to a mapped slot: map read, evaluate; free: map read, evaluate, each map slot
//   in turn; write to an unmapped slot: map read, evaluate, free bitmap scanned eight
//   blocks a cycle; an idle state precedes the next item; one item in flight at a time
// the file map row and the data row are each one registered memory read
// reset is synchronous, active low: all files empty, all blocks free, all bytes
// zero, with no clearing pass (per-file and per-row valid flops are cleared)
// a finished result waits in the output register while the next item is taken;
// if the receiver still stalls when that item finishes, the block holds it and
// keeps s_tready low until the earlier result is taken
module block_mapped_byte_store_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmbs_pkg::S_DATA_W-1:0] s_tdata,  // mode, file_id, offset, write_data
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmbs_pkg::M_DATA_W-1:0] m_tdata   // status, read_data
);
    import bmbs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    bmbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bmbs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule
